// ===== src/exrzip_pkg.sv =====
// Shared types and constants for the scanline predictor / de-interleave block.
// Used by exrzip_front, exrzip_emit and the top level under src; depends on nothing.
package exrzip_pkg;

  localparam int BYTE_W             = 8;
  localparam int LINE_LEN_W         = 17;
  localparam int MAX_LINE_BYTES_DEF = 65536;

  // Predictor bias and reset value of the length register
  localparam logic [BYTE_W-1:0]     PRED_BIAS = 8'd128;
  localparam logic [LINE_LEN_W-1:0] LEN_RESET = 17'd1;

  // What one accepted byte asks of the emitter
  typedef enum logic {
    KIND_SINGLE,  // line of length one: emit the byte alone
    KIND_PAIR     // second-half byte: stored byte, then itself
  } item_kind_t;

  typedef struct packed {
    item_kind_t              kind;
    logic [BYTE_W-1:0]       dec;   // decoded byte
    logic                    last;  // final input of the line
    logic                    tail;  // odd line: one more stored byte follows
  } item_t;

endpackage

// ===== src/exrzip_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read.
// Self-contained; no package needed.
module exrzip_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32768,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/exrzip_front.sv =====
// Input side: delta predictor, line position counter, length register and
// store port control. Depends on exrzip_pkg.
module exrzip_front #(
  parameter int MAX_LINE_BYTES = exrzip_pkg::MAX_LINE_BYTES_DEF,
  localparam int STORE_DEPTH = (MAX_LINE_BYTES + 1) / 2,
  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration
  input  logic                                cfg_wr_en,
  input  logic [exrzip_pkg::LINE_LEN_W-1:0]   cfg_line_length,
  // input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [exrzip_pkg::BYTE_W-1:0]       in_byte_in,
  // emitter handshake
  input  logic                                take_ok,
  input  logic                                tail_rd,
  output logic                                push,
  output exrzip_pkg::item_t                   item,
  // store port
  output logic                                ram_we,
  output logic [AW-1:0]                       ram_waddr,
  output logic [exrzip_pkg::BYTE_W-1:0]       ram_wdata,
  output logic                                ram_re,
  output logic [AW-1:0]                       ram_raddr
);

  localparam int PW = $clog2(MAX_LINE_BYTES);
  localparam int LW = $clog2(MAX_LINE_BYTES + 1);
  localparam int CW = (LW > exrzip_pkg::LINE_LEN_W) ? LW : exrzip_pkg::LINE_LEN_W;

  logic [PW-1:0]                   pos_r, pos_nxt;
  logic [exrzip_pkg::BYTE_W-1:0]   prev_r, prev_nxt;
  logic [LW-1:0]                   half_r, half_nxt;
  logic [PW-1:0]                   lastpos_r, lastpos_nxt;
  logic                            odd_r, odd_nxt;

  logic                            accept;
  logic                            first_half;
  logic                            is_last;
  logic [exrzip_pkg::BYTE_W-1:0]   dec;
  logic [LW-1:0]                   pos_ext;
  logic [CW-1:0]                   ll_ext;
  logic [CW-1:0]                   len_clamped;

  assign in_ready = take_ok;
  assign accept   = in_valid && take_ok;

  assign pos_ext    = LW'(pos_r);
  assign first_half = pos_ext < half_r;
  assign is_last    = (pos_r == lastpos_r);

  // Predictor: first byte of a line passes, later ones add the bias-removed delta
  assign dec = (pos_r == '0) ? in_byte_in
                             : in_byte_in - exrzip_pkg::PRED_BIAS + prev_r;

  // Length clamp: zero acts as one, oversize acts as the maximum
  assign ll_ext = CW'(cfg_line_length);
  always_comb begin
    if (ll_ext == '0) begin
      len_clamped = CW'(1);
    end else if (ll_ext > CW'(MAX_LINE_BYTES)) begin
      len_clamped = CW'(MAX_LINE_BYTES);
    end else begin
      len_clamped = ll_ext;
    end
  end

  // Store port: first-half write, second-half read, or the odd-line tail read
  assign ram_we    = accept && first_half;
  assign ram_waddr = AW'(pos_r);
  assign ram_wdata = dec;
  assign ram_re    = (accept && !first_half) || tail_rd;
  assign ram_raddr = tail_rd ? AW'(half_r - LW'(1)) : AW'(pos_ext - half_r);

  // Item handed to the emitter
  assign push = accept && (!first_half || (lastpos_r == '0));
  always_comb begin
    item.kind = first_half ? exrzip_pkg::KIND_SINGLE : exrzip_pkg::KIND_PAIR;
    item.dec  = dec;
    item.last = is_last;
    item.tail = is_last && odd_r && !first_half;
  end

  // Next state of position, predictor history and length registers
  always_comb begin
    pos_nxt     = pos_r;
    prev_nxt    = prev_r;
    half_nxt    = half_r;
    lastpos_nxt = lastpos_r;
    odd_nxt     = odd_r;
    if (cfg_wr_en) begin
      pos_nxt     = '0;
      prev_nxt    = '0;
      half_nxt    = LW'((len_clamped + CW'(1)) >> 1);
      lastpos_nxt = PW'(len_clamped - CW'(1));
      odd_nxt     = len_clamped[0];
    end else if (accept) begin
      if (is_last) begin
        pos_nxt  = '0;
        prev_nxt = '0;
      end else begin
        pos_nxt  = pos_r + PW'(1);
        prev_nxt = dec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      prev_r    <= '0;
      half_r    <= LW'(1);
      lastpos_r <= PW'(exrzip_pkg::LEN_RESET - 1'b1);
      odd_r     <= exrzip_pkg::LEN_RESET[0];
    end else begin
      pos_r     <= pos_nxt;
      prev_r    <= prev_nxt;
      half_r    <= half_nxt;
      lastpos_r <= lastpos_nxt;
      odd_r     <= odd_nxt;
    end
  end

`ifndef SYNTHESIS
  // Tail read only happens while no byte is taken, so the port never collides
  a_no_port_clash: assert property (@(posedge clk) disable iff (!rst_n)
    tail_rd |-> !accept)
    else $error("tail read collides with an accepted byte");

  // A length write restarts the line
  a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en |=> (pos_r == '0) && (prev_r == '0))
    else $error("line did not restart after length write");

  // The final byte of a line always returns the position to zero
  a_line_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_last && !cfg_wr_en) |=> (pos_r == '0))
    else $error("position did not wrap at end of line");
`endif

endmodule

// ===== src/exrzip_emit.sv =====
// Output side: per-item beat sequencer and the output register.
// Depends on exrzip_pkg.
module exrzip_emit (
  input  logic                            clk,
  input  logic                            rst_n,
  // from the front end
  input  logic                            push,
  input  exrzip_pkg::item_t               item,
  output logic                            take_ok,
  output logic                            tail_rd,
  // store read data
  input  logic [exrzip_pkg::BYTE_W-1:0]   rdata,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [exrzip_pkg::BYTE_W-1:0]   out_byte_out,
  output logic                            out_end_of_line
);

  typedef enum logic [1:0] {
    PH_STORED,  // stored first-half byte
    PH_OWN,     // the item's own decoded byte
    PH_TAIL     // last stored byte of an odd line
  } phase_t;

  logic                          busy_r, busy_nxt;
  phase_t                        ph_r, ph_nxt;
  exrzip_pkg::item_t             item_r, item_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [exrzip_pkg::BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic                          out_eol_r, out_eol_nxt;

  logic                          adv;
  logic                          last_ph;
  logic [exrzip_pkg::BYTE_W-1:0] beat_byte;
  logic                          beat_eol;

  // While an item is active, one beat moves into the output register whenever it is free or drains
  assign adv     = busy_r && (!out_valid_r || out_ready);
  assign last_ph = ((ph_r == PH_OWN) && !item_r.tail) || (ph_r == PH_TAIL);
  assign take_ok = !busy_r || (adv && last_ph);
  assign tail_rd = adv && (ph_r == PH_OWN) && item_r.tail;

  // Beat selection by phase
  always_comb begin
    case (ph_r)
      PH_STORED: begin
        beat_byte = rdata;
        beat_eol  = 1'b0;
      end
      PH_OWN: begin
        beat_byte = item_r.dec;
        beat_eol  = item_r.last && !item_r.tail;
      end
      PH_TAIL: begin
        beat_byte = rdata;
        beat_eol  = 1'b1;
      end
      default: begin
        beat_byte = item_r.dec;
        beat_eol  = 1'b0;
      end
    endcase
  end

  // Sequencer and output register next state
  always_comb begin
    busy_nxt      = busy_r;
    ph_nxt        = ph_r;
    item_nxt      = item_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_eol_nxt   = out_eol_r;

    if (push) begin
      busy_nxt = 1'b1;
      item_nxt = item;
      ph_nxt   = (item.kind == exrzip_pkg::KIND_SINGLE) ? PH_OWN : PH_STORED;
    end else if (adv && last_ph) begin
      busy_nxt = 1'b0;
    end else if (adv) begin
      ph_nxt = (ph_r == PH_STORED) ? PH_OWN : PH_TAIL;
    end

    if (adv) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = beat_byte;
      out_eol_nxt   = beat_eol;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      ph_r        <= PH_OWN;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      ph_r        <= ph_nxt;
      out_valid_r <= out_valid_nxt;
    end
    item_r     <= item_nxt;
    out_byte_r <= out_byte_nxt;
    out_eol_r  <= out_eol_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_byte_out    = out_byte_r;
  assign out_end_of_line = out_eol_r;

`ifndef SYNTHESIS
  // The front end only hands over an item when the sequencer can take it
  a_push_ok: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> take_ok)
    else $error("item pushed while sequencer busy");

  // A pair item always starts on its stored byte
  a_pair_start: assert property (@(posedge clk) disable iff (!rst_n)
    (push && (item.kind == exrzip_pkg::KIND_PAIR)) |=> (busy_r && (ph_r == PH_STORED)))
    else $error("pair item did not start on the stored byte");

  // The tail beat closes the line
  a_tail_eol: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && (ph_r == PH_TAIL)) |=> (out_valid_r && out_eol_r))
    else $error("tail beat without end of line");

  // Store is read for the tail only while a result slot is moving
  a_tail_rd: assert property (@(posedge clk) disable iff (!rst_n)
    tail_rd |-> (busy_r && !take_ok))
    else $error("tail read outside an active odd-line item");
`endif

endmodule

// ===== src/exr_zip_predictor_deinterleave.sv =====
// Top level of the scanline post-inflate stage: predictor plus byte de-interleave.
// Depends on exrzip_pkg, exrzip_ram, exrzip_front and exrzip_emit.
//
// Takes one inflated byte per beat and returns the decoded line in interleaved
// order, with out_end_of_line on its final byte. cfg_line_length (0 acts as 1,
// values above MAX_LINE_BYTES act as MAX_LINE_BYTES) restarts the line when
// written; write it only while the block is idle. Bytes of the first half of a
// line are accepted one per cycle while no earlier beats wait, and give no
// result unless the line has length one; they go into an internal store of
// ceil(MAX_LINE_BYTES/2) bytes with a single read port. Each second-half byte
// yields two result beats, which leave one per cycle while out_ready holds; the
// last byte of an odd line yields three beats, as the last stored byte needs a
// second read of the store. An accepted byte is registered, then its beats
// leave via the output register. The store needs no initialization after reset.
module exr_zip_predictor_deinterleave #(
  parameter int MAX_LINE_BYTES = exrzip_pkg::MAX_LINE_BYTES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [exrzip_pkg::LINE_LEN_W-1:0] cfg_line_length,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [exrzip_pkg::BYTE_W-1:0]     in_byte_in,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [exrzip_pkg::BYTE_W-1:0]     out_byte_out,
  output logic                              out_end_of_line
);

  localparam int STORE_DEPTH = (MAX_LINE_BYTES + 1) / 2;
  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  logic                          take_ok;
  logic                          tail_rd;
  logic                          push;
  exrzip_pkg::item_t             item;
  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  logic [exrzip_pkg::BYTE_W-1:0] ram_wdata;
  logic                          ram_re;
  logic [AW-1:0]                 ram_raddr;
  logic [exrzip_pkg::BYTE_W-1:0] ram_rdata;

  exrzip_front #(
    .MAX_LINE_BYTES (MAX_LINE_BYTES)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_line_length (cfg_line_length),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_byte_in      (in_byte_in),
    .take_ok         (take_ok),
    .tail_rd         (tail_rd),
    .push            (push),
    .item            (item),
    .ram_we          (ram_we),
    .ram_waddr       (ram_waddr),
    .ram_wdata       (ram_wdata),
    .ram_re          (ram_re),
    .ram_raddr       (ram_raddr)
  );

  // First-half byte store
  exrzip_ram #(
    .WIDTH (exrzip_pkg::BYTE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  exrzip_emit u_emit (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .item            (item),
    .take_ok         (take_ok),
    .tail_rd         (tail_rd),
    .rdata           (ram_rdata),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte_out    (out_byte_out),
    .out_end_of_line (out_end_of_line)
  );

endmodule

// ===== bench/tb_exr_zip_predictor_deinterleave.sv =====
`timescale 1ns / 100ps
// Self-checking bench for exr_zip_predictor_deinterleave: sends inflated scanline
// bytes, predicts the decoded, interleaved output beats and compares them.
// Depends on exrzip_pkg and the block's RTL.
module tb_exr_zip_predictor_deinterleave;

  localparam int MAX_BYTES  = exrzip_pkg::MAX_LINE_BYTES_DEF;
  localparam int STORE_SIZE = (MAX_BYTES + 1) / 2;

  typedef struct {
    logic [exrzip_pkg::BYTE_W-1:0] data;
    logic                          eol;
  } line_beat_t;

  logic                              clk             = 1'b0;
  logic                              rst_n           = 1'b0;
  logic                              cfg_wr_en       = 1'b0;
  logic [exrzip_pkg::LINE_LEN_W-1:0] cfg_line_length = '0;
  logic                              in_valid        = 1'b0;
  logic                              in_ready;
  logic [exrzip_pkg::BYTE_W-1:0]     in_byte_in      = '0;
  logic                              out_valid;
  logic                              out_ready       = 1'b0;
  logic [exrzip_pkg::BYTE_W-1:0]     out_byte_out;
  logic                              out_end_of_line;

  // Decoder image: length register, predictor state and first-half bytes
  logic [exrzip_pkg::LINE_LEN_W-1:0] line_len_reg = exrzip_pkg::LEN_RESET;
  logic [exrzip_pkg::BYTE_W-1:0]     prev_decoded = '0;
  int unsigned                       line_pos     = 0;
  logic [exrzip_pkg::BYTE_W-1:0]     first_half_bytes [STORE_SIZE];

  line_beat_t pending_beats[$];
  int         fail_count = 0;
  bit         steady     = 1'b0;  // no idling on either side while set

  exr_zip_predictor_deinterleave #(
    .MAX_LINE_BYTES(MAX_BYTES)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_line_length(cfg_line_length),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte_in     (in_byte_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte_out   (out_byte_out),
    .out_end_of_line(out_end_of_line)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Result-side stalls
  always @(negedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 33);
  end

  // Decode one accepted byte and queue the beats it produces
  function automatic void decode_byte(input logic [exrzip_pkg::BYTE_W-1:0] raw);
    int unsigned                   len;
    int unsigned                   half;
    int unsigned                   j;
    logic                          last;
    logic [exrzip_pkg::BYTE_W-1:0] dec;
    if (line_len_reg == '0) begin
      len = 1;
    end else if (line_len_reg > MAX_BYTES) begin
      len = MAX_BYTES;
    end else begin
      len = line_len_reg;
    end
    half = (len + 1) / 2;
    if (line_pos == 0) begin
      dec = raw;
    end else begin
      dec = raw - exrzip_pkg::PRED_BIAS + prev_decoded;
    end
    prev_decoded = dec;
    if (line_pos < half) begin
      first_half_bytes[line_pos] = dec;
      if (len == 1) begin
        pending_beats.push_back('{data: dec, eol: 1'b1});
        line_pos     = 0;
        prev_decoded = '0;
      end else begin
        line_pos++;
      end
    end else begin
      j    = line_pos - half;
      last = (line_pos + 1 >= len);
      pending_beats.push_back('{data: first_half_bytes[j], eol: 1'b0});
      if (last && len[0]) begin
        // odd line: the last stored byte closes it
        pending_beats.push_back('{data: dec, eol: 1'b0});
        pending_beats.push_back('{data: first_half_bytes[half-1], eol: 1'b1});
      end else begin
        pending_beats.push_back('{data: dec, eol: last});
      end
      if (last) begin
        line_pos     = 0;
        prev_decoded = '0;
      end else begin
        line_pos++;
      end
    end
  endfunction

  // One input beat; valid stays high when the next byte follows at once
  task automatic send_byte(input logic [exrzip_pkg::BYTE_W-1:0] value);
    while (!steady && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_byte_in <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    decode_byte(value);
    @(negedge clk);
  endtask

  // Length write once the block has drained; restarts the line
  task automatic write_line_length(input logic [exrzip_pkg::LINE_LEN_W-1:0] value);
    in_valid <= 1'b0;
    while (pending_beats.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
    cfg_wr_en       <= 1'b1;
    cfg_line_length <= value;
    @(negedge clk);
    cfg_wr_en    <= 1'b0;
    line_len_reg  = value;
    line_pos      = 0;
    prev_decoded  = '0;
  endtask

  // Compare each output beat with the oldest expected one
  always @(posedge clk) begin
    line_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_beats.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected beat: expected none, got byte_out %02h end_of_line %b",
                 $time, out_byte_out, out_end_of_line);
      end else begin
        want = pending_beats.pop_front();
        if (out_byte_out !== want.data) begin
          fail_count++;
          $display("%0t: byte_out mismatch: expected %02h, got %02h",
                   $time, want.data, out_byte_out);
        end
        if (out_end_of_line !== want.eol) begin
          fail_count++;
          $display("%0t: end_of_line mismatch: expected %b, got %b",
                   $time, want.eol, out_end_of_line);
        end
      end
    end
  end

  // Byte extremes, the length corners from zero to four and the maximum, and a restart part way through a line
  task automatic test_directed();
    // reset length is one: each byte is a line of its own
    send_byte(8'h00);
    send_byte(8'hFF);
    write_line_length('0);
    send_byte(8'hA5);
    write_line_length(exrzip_pkg::LINE_LEN_W'(1));
    send_byte(8'h5A);
    write_line_length(exrzip_pkg::LINE_LEN_W'(2));
    send_byte(8'hFF);
    send_byte(8'h00);
    write_line_length(exrzip_pkg::LINE_LEN_W'(3));
    send_byte(8'h80);
    send_byte(8'h7F);
    send_byte(8'h01);
    write_line_length(exrzip_pkg::LINE_LEN_W'(4));
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(8'h80);
    write_line_length(exrzip_pkg::LINE_LEN_W'(MAX_BYTES));
    send_byte(8'h12);
    send_byte(8'h34);
    // restart in the first half, then two lines back to back
    write_line_length(exrzip_pkg::LINE_LEN_W'(5));
    repeat (5) send_byte(8'hFF);
    repeat (5) send_byte(8'h00);
  endtask

  // Mostly whole lines of random short lengths, some cut short
  task automatic test_random_lines();
    int unsigned                       sent;
    int unsigned                       eff;
    int unsigned                       count;
    logic [exrzip_pkg::LINE_LEN_W-1:0] len_sel;
    sent    = 0;
    len_sel = exrzip_pkg::LEN_RESET;
    while (sent < 210) begin
      steady = (sent >= 80 && sent < 150);
      if (sent == 0 || $urandom_range(2) == 0) begin
        case ($urandom_range(9))
          0:       len_sel = '0;
          1:       len_sel = exrzip_pkg::LINE_LEN_W'(1);
          7, 8:    len_sel = exrzip_pkg::LINE_LEN_W'($urandom_range(40, 10));
          default: len_sel = exrzip_pkg::LINE_LEN_W'($urandom_range(9, 2));
        endcase
        write_line_length(len_sel);
      end
      eff = (len_sel == '0) ? 1 : len_sel;
      // a cut-short line runs on into the next one unless the length is rewritten
      if (eff > 1 && $urandom_range(7) == 0) begin
        count = $urandom_range(eff - 1, 1);
      end else begin
        count = eff;
      end
      repeat (count) send_byte(exrzip_pkg::BYTE_W'($urandom_range(255)));
      sent += count;
    end
    steady = 1'b0;
  endtask

  // Oversize length clamps to the largest line: these bytes stay in the first half
  task automatic test_oversize_line();
    write_line_length('1);
    repeat (12) send_byte(exrzip_pkg::BYTE_W'($urandom_range(255)));
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_lines();
    test_oversize_line();
    in_valid <= 1'b0;
    while (pending_beats.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("exr_zip_predictor_deinterleave test passed");
    end else begin
      $display("exr_zip_predictor_deinterleave test failed");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("exr_zip_predictor_deinterleave test failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/exrzip_pkg.sv
src/exrzip_ram.sv
src/exrzip_front.sv
src/exrzip_emit.sv
src/exr_zip_predictor_deinterleave.sv
bench/tb_exr_zip_predictor_deinterleave.sv
